// ===== rtl/core/smt_pkg.sv =====
// shared types and constants of the sled motion tracker
package smt_pkg;

	// request codes on the input side
	localparam logic [1:0] REQ_EDGE   = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_STATUS = 2'd2;

	// queue sizing between the parts
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// angle and turn arithmetic
	localparam int ANGLE_W    = 12;
	localparam int WORD_W     = 32;
	localparam int TURN_W     = WORD_W - ANGLE_W;
	localparam int DIFF_W     = ANGLE_W + 1;
	localparam int STEP_W     = ANGLE_W + 2;
	localparam int HALF_TURN  = 2048;
	localparam int FULL_TURN  = 4096;

	// classified command kinds
	typedef enum logic [1:0] {
		CMD_EDGE,
		CMD_TICK,
		CMD_STATUS
	} cmd_kind_t;

	// indicator modes
	typedef enum logic [1:0] {
		LED_FAIL    = 2'd0,
		LED_CONTACT = 2'd1,
		LED_FREE    = 2'd2
	} led_t;

	// command passed from front to back
	typedef struct packed {
		cmd_kind_t            kind;
		logic                 up;
		logic                 touching;
		logic [ANGLE_W-1:0]   angle;
		logic                 ok;
	} cmd_t;

	// snapshot item
	typedef struct packed {
		logic                 side;
		logic [WORD_W-1:0]    move_delta;
		logic [WORD_W-1:0]    turn_delta;
		logic [WORD_W-1:0]    move_abs;
		logic [WORD_W-1:0]    turn_abs;
		logic [WORD_W-1:0]    msg_number;
		led_t                 led;
	} rslt_t;

	// handshake between front and back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_link_t;

endpackage

// ===== rtl/core/sled_motion_tracker_unit.sv =====
// top level of the sled motion tracker
// Tracks one locomotion sled: encoder edges step the absolute position (and the
// move delta while the contact pin is low), send ticks unwrap the 12-bit angle
// into a 32-bit turn position, accumulate the turn delta in contact and queue one
// snapshot, and send status items clear both deltas or flag a failed send. Items
// are accepted one per clock whenever full is low; a front queue of four commands
// feeds the state-update stage, which retires one command per clock unless a tick
// finds the result queue full. A result queue of four snapshots decouples pop and
// drives the result ports from its head, and the back end stalls a tick only when
// that queue is full. Request code 3 is dropped at the input. rail_side is written
// through cfg_valid/cfg_data (cfg_ready is always high); the user must write it
// only while idle, as the block itself does not enforce this.
module sled_motion_tracker_unit import smt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               req_type,
	input  logic                     dir_level,
	input  logic                     contact_level,
	input  logic [ANGLE_W-1:0]       raw_angle,
	input  logic                     send_ok,
	output logic                     empty,
	input  logic                     pop,
	output logic                     side_out,
	output logic signed [WORD_W-1:0] move_delta_out,
	output logic signed [WORD_W-1:0] turn_delta_out,
	output logic signed [WORD_W-1:0] move_abs_out,
	output logic signed [WORD_W-1:0] turn_abs_out,
	output logic [WORD_W-1:0]        msg_number,
	output logic [1:0]               indicator,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_data
);

	logic      rail_side_q;
	cmd_link_t link;
	logic      cmd_pop;
	logic      rq_full;
	logic      rq_wr;
	rslt_t     rq_wdata;
	rslt_t     rq_rdata;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_side_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			rail_side_q <= cfg_data;
		end
	end

	smt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.dir_level     (dir_level),
		.contact_level (contact_level),
		.raw_angle     (raw_angle),
		.send_ok       (send_ok),
		.link          (link),
		.cmd_pop       (cmd_pop)
	);

	smt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.link    (link),
		.cmd_pop (cmd_pop),
		.side    (rail_side_q),
		.rq_full (rq_full),
		.rq_wr   (rq_wr),
		.rq_data (rq_wdata)
	);

	smt_rslt_q u_rslt_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_wr),
		.wr_data (rq_wdata),
		.q_full  (rq_full),
		.pop     (pop),
		.empty   (empty),
		.rd_data (rq_rdata)
	);

	// result fields from the head of the queue
	assign side_out       = rq_rdata.side;
	assign move_delta_out = $signed(rq_rdata.move_delta);
	assign turn_delta_out = $signed(rq_rdata.turn_delta);
	assign move_abs_out   = $signed(rq_rdata.move_abs);
	assign turn_abs_out   = $signed(rq_rdata.turn_abs);
	assign msg_number     = rq_rdata.msg_number;
	assign indicator      = rq_rdata.led;

endmodule

// ===== rtl/core/smt_front.sv =====
// front end: accepts items, classifies them and queues commands for the back end
module smt_front import smt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic               dir_level,
	input  logic               contact_level,
	input  logic [ANGLE_W-1:0] raw_angle,
	input  logic               send_ok,
	output cmd_link_t          link,
	input  logic               cmd_pop
);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             cmd_in;
	logic             known;
	logic             wr_en;
	logic             rd_en;

	// classify the incoming item
	always_comb begin
		cmd_in.up       = dir_level;
		cmd_in.touching = ~contact_level;
		cmd_in.angle    = raw_angle;
		cmd_in.ok       = send_ok;
		cmd_in.kind     = CMD_EDGE;
		known           = 1'b1;
		case (req_type)
			REQ_EDGE:   cmd_in.kind = CMD_EDGE;
			REQ_TICK:   cmd_in.kind = CMD_TICK;
			REQ_STATUS: cmd_in.kind = CMD_STATUS;
			default:    known = 1'b0;
		endcase
	end

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign wr_en = push & ~full & known;
	assign rd_en = cmd_pop & link.valid;

	assign link.valid = (count_q != '0);
	assign link.cmd   = mem_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (wr_en && !rd_en) count_q <= count_q + CNT_W'(1);
			else if (!wr_en && rd_en) count_q <= count_q - CNT_W'(1);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= cmd_in;
	end

endmodule

// ===== rtl/core/smt_rslt_q.sv =====
// result queue holding snapshots until they are popped
module smt_rslt_q import smt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  rslt_t wr_data,
	output logic  q_full,
	input  logic  pop,
	output logic  empty,
	output rslt_t rd_data
);

	rslt_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~q_full;
	assign do_rd   = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd) count_q <= count_q + CNT_W'(1);
			else if (!do_wr && do_rd) count_q <= count_q - CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== rtl/core/smt_back.sv =====
// back end: tracker state, angle unwrapping and snapshot generation
module smt_back import smt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_link_t link,
	output logic      cmd_pop,
	input  logic      side,
	input  logic      rq_full,
	output logic      rq_wr,
	output rslt_t     rq_data
);

	logic [WORD_W-1:0]  move_abs_q;
	logic [WORD_W-1:0]  move_delta_q;
	logic [WORD_W-1:0]  turn_delta_q;
	logic [WORD_W-1:0]  seq_q;
	logic [TURN_W-1:0]  turn_count_q;
	logic [ANGLE_W-1:0] prev_angle_q;
	logic               first_seen_q;
	led_t               led_q;

	logic signed [DIFF_W-1:0] diff;
	logic                     wrap_up;
	logic                     wrap_dn;
	logic signed [STEP_W-1:0] step;
	logic [TURN_W-1:0]        turn_count_nxt;
	logic [WORD_W-1:0]        turn_delta_nxt;
	led_t                     led_tick;
	logic [WORD_W-1:0]        move_step;
	logic                     is_tick;
	logic                     go;

	// take a command unless it is a tick and the result queue has no room
	assign is_tick = (link.cmd.kind == CMD_TICK);
	assign go      = link.valid & (~is_tick | ~rq_full);
	assign cmd_pop = go;
	assign rq_wr   = go & is_tick;

	// half-turn unwrap: turn-delta step is the old angle less the new, less whole turns crossed
	always_comb begin
		diff    = $signed({1'b0, prev_angle_q}) - $signed({1'b0, link.cmd.angle});
		wrap_up = first_seen_q & (diff > DIFF_W'(HALF_TURN));
		wrap_dn = first_seen_q & (diff < -DIFF_W'(HALF_TURN));
		if (!first_seen_q) step = '0;
		else if (wrap_up) step = STEP_W'(diff) - STEP_W'(FULL_TURN);
		else if (wrap_dn) step = STEP_W'(diff) + STEP_W'(FULL_TURN);
		else step = STEP_W'(diff);
		if (wrap_up) turn_count_nxt = turn_count_q + TURN_W'(1);
		else if (wrap_dn) turn_count_nxt = turn_count_q - TURN_W'(1);
		else turn_count_nxt = turn_count_q;
		if (link.cmd.touching) turn_delta_nxt = turn_delta_q + WORD_W'(step);
		else turn_delta_nxt = turn_delta_q;
	end

	// indicator update on a tick
	always_comb begin
		led_tick = led_q;
		if (link.cmd.touching) begin
			if (led_q == LED_FREE) led_tick = LED_CONTACT;
		end else begin
			if (led_q == LED_CONTACT) led_tick = LED_FREE;
		end
	end

	assign move_step = link.cmd.up ? WORD_W'(1) : '1;

	// snapshot contents
	always_comb begin
		rq_data.side       = side;
		rq_data.move_delta = move_delta_q;
		rq_data.turn_delta = turn_delta_nxt;
		rq_data.move_abs   = move_abs_q;
		rq_data.turn_abs   = {turn_count_nxt, link.cmd.angle};
		rq_data.msg_number = seq_q;
		rq_data.led        = led_tick;
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_abs_q   <= '0;
			move_delta_q <= '0;
			turn_delta_q <= '0;
			seq_q        <= '0;
			turn_count_q <= '0;
			prev_angle_q <= '0;
			first_seen_q <= 1'b0;
			led_q        <= LED_CONTACT;
		end else if (go) begin
			case (link.cmd.kind)
				CMD_EDGE: begin
					move_abs_q <= move_abs_q + move_step;
					if (link.cmd.touching) move_delta_q <= move_delta_q + move_step;
				end
				CMD_TICK: begin
					turn_count_q <= turn_count_nxt;
					prev_angle_q <= link.cmd.angle;
					first_seen_q <= 1'b1;
					turn_delta_q <= turn_delta_nxt;
					led_q        <= led_tick;
					seq_q        <= seq_q + WORD_W'(1);
				end
				CMD_STATUS: begin
					if (link.cmd.ok) begin
						if (led_q == LED_FAIL) led_q <= LED_CONTACT;
						move_delta_q <= '0;
						turn_delta_q <= '0;
					end else begin
						led_q <= LED_FAIL;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
